@@ rtl/pv_current_from_voltage_unit_defines.svh @@
// Assertion macros shared by the photovoltaic current unit.
`ifndef PV_CURRENT_FROM_VOLTAGE_UNIT_DEFINES_SVH
`define PV_CURRENT_FROM_VOLTAGE_UNIT_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define PVCUR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true out of reset.
`define PVCUR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/pvcur_pkg.sv @@
// Package: constants, types and exponent table of the photovoltaic current unit.
package pvcur_pkg;

  localparam int unsigned ADC_BITS        = 10;
  localparam int unsigned DAC_BITS        = 12;
  localparam int unsigned EXP_TABLE_DEPTH = 64;

  localparam int unsigned CODE_W     = 12;
  localparam int unsigned SPI_W      = 16;
  localparam int unsigned IRR_W      = 16;
  localparam int unsigned TEMP_W     = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IRRADIANCE  = 2'd0,
    REG_TEMPERATURE = 2'd1
  } cfg_reg_e;

  localparam logic [IRR_W-1:0]  IRR_RESET  = 16'd900;
  localparam logic [TEMP_W-1:0] TEMP_RESET = 8'd25;

  localparam logic [63:0]       ADC_MAX     = (64'd1 << ADC_BITS) - 64'd1;
  localparam logic [CODE_W-1:0] DAC_MAX     = CODE_W'((1 << DAC_BITS) - 1);
  localparam logic [CODE_W-1:0] VLIMIT_CODE = (4092 > ((1 << DAC_BITS) - 1)) ?
                                              DAC_MAX : CODE_W'(4092);
  localparam logic [SPI_W-1:0]  SPI_CMD     = 16'h1000;

  // Exponent in base 2, Q32 with bias
  localparam logic [63:0] LOG2E_Q32 = 64'd6196328019;
  localparam logic [63:0] LN2_Q30   = 64'd744261118;
  localparam logic [63:0] ONE_Q30   = 64'd1073741824;
  localparam int unsigned EXP_BIAS  = 32;
  localparam int unsigned HUGE_EXP  = 7;

  localparam int unsigned FRAC_W  = 32;
  localparam int unsigned XS_W    = 38;
  localparam int unsigned HI_W    = XS_W - FRAC_W;
  localparam int unsigned SLOPE_W = 32;
  localparam int unsigned SHIFT_W = 5;

  localparam logic [SLOPE_W-1:0] TEMP_SLOPE =
    SLOPE_W'((64'd38 * LOG2E_Q32 + 64'd500) / 64'd1000);
  localparam logic [SLOPE_W-1:0] ADC_SLOPE =
    SLOPE_W'((64'd1415 * LOG2E_Q32 + 64'd50 * ADC_MAX) / (64'd100 * ADC_MAX));
  localparam logic [XS_W-1:0] XS_BASE =
    XS_W'((64'(EXP_BIAS) << FRAC_W) - 64'd10 * LOG2E_Q32 - 64'd25 * 64'(TEMP_SLOPE));
  localparam logic [HI_W-1:0] HUGE_HI = HI_W'(EXP_BIAS + HUGE_EXP);
  localparam logic [HI_W-1:0] S_BASE  = HI_W'(EXP_BIAS + 14);

  // Positive term (84*irr + 5600) * 2^16 / 30, split as A*2184 + (8A+7)/15
  localparam int unsigned A_W       = 23;
  localparam int unsigned POS_W     = 35;
  localparam int unsigned POS_FRAC  = 16;
  localparam int unsigned RAW_W     = POS_W - POS_FRAC;
  localparam int unsigned DIV15_W   = 27;
  localparam int unsigned DIV15_SH  = 30;
  localparam int unsigned PY_W      = A_W + 3 + DIV15_W;
  localparam logic [A_W-1:0]     POS_A_MUL  = 23'd84;
  localparam logic [A_W-1:0]     POS_A_ADD  = 23'd5600;
  localparam logic [POS_W-1:0]   POS_HI_MUL = 35'd2184;
  localparam logic [DIV15_W-1:0] DIV15_M    =
    DIV15_W'(((64'd1 << DIV15_SH) + 64'd14) / 64'd15);

  // Exponential term 5600/3 * m, split as 1866*m + (2m)/3
  localparam int unsigned ROM_W     = 32;
  localparam int unsigned IDX_W     = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned REM_W     = FRAC_W - IDX_W;
  localparam int unsigned PROD_W    = ROM_W + REM_W;
  localparam int unsigned NEG_SUM_W = 46;
  localparam int unsigned DIV3_W    = ROM_W + 1;
  localparam int unsigned DIV3_SH   = 34;
  localparam int unsigned MLO_W     = 2 * DIV3_W;
  localparam logic [NEG_SUM_W-1:0] EXP_MUL_HI = NEG_SUM_W'(5600 / 3);
  localparam logic [DIV3_W-1:0]    DIV3_M     =
    DIV3_W'(((64'd1 << DIV3_SH) + 64'd2) / 64'd3);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  typedef struct packed {
    logic [SHIFT_W-1:0] shamt;
    logic               huge;
    logic [POS_W-1:0]   pos;
  } pvcur_ctl_t;

  typedef struct packed {
    logic [FRAC_W-1:0] frac;
    pvcur_ctl_t        ctl;
  } pvcur_entry_t;

  typedef logic [ROM_W-1:0] exp_rom_t [EXP_TABLE_DEPTH+1];

  // 2^(k/DEPTH) in Q30 from a truncated series
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      y    = (64'(k) * LN2_Q30 + 64'(EXP_TABLE_DEPTH / 2)) / 64'(EXP_TABLE_DEPTH);
      term = ONE_Q30;
      sum  = ONE_Q30;
      for (int j = 1; j < 24; j++) begin
        if (term != 64'd0) begin
          term = ((term * y) >> 30) / 64'(j);
          sum  = sum + term;
        end
      end
      rom[k] = ROM_W'(sum);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

@@ rtl/pvcur_front.sv @@
// Front end: accepts samples, forms the exponent and the positive current term.
module pvcur_front import pvcur_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ADC_BITS-1:0] adc_sample_i,
  input  logic [IRR_W-1:0]    irradiance_i,
  input  logic [TEMP_W-1:0]   temperature_i,
  input  logic                full_i,
  output logic                push_o,
  output pvcur_entry_t        entry_o
);

  logic adv;

  logic             f1_valid_q;
  logic [XS_W-1:0]  pt_q;
  logic [XS_W-1:0]  pa_q;
  logic [A_W-1:0]   a_q;

  logic             f2_valid_q;
  logic [XS_W-1:0]  xs_q;
  logic [POS_W-1:0] apos_q;
  logic [PY_W-1:0]  py_q;

  logic [HI_W-1:0]  hi;

  assign adv        = !(f2_valid_q && full_i);
  assign in_ready_o = adv;
  assign push_o     = f2_valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= in_valid_i;
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      pt_q <= XS_W'(TEMP_SLOPE) * XS_W'(temperature_i);
      pa_q <= XS_W'(ADC_SLOPE) * XS_W'(adc_sample_i);
      a_q  <= A_W'(irradiance_i) * POS_A_MUL + POS_A_ADD;
    end
    if (adv && f1_valid_q) begin
      xs_q   <= XS_BASE + pt_q + pa_q;
      apos_q <= POS_W'(a_q) * POS_HI_MUL;
      py_q   <= PY_W'({a_q, 3'b111}) * PY_W'(DIV15_M);
    end
  end

  always_comb begin
    hi                  = xs_q[XS_W-1:FRAC_W];
    entry_o.frac        = xs_q[FRAC_W-1:0];
    entry_o.ctl.huge    = (hi >= HUGE_HI);
    entry_o.ctl.shamt   = SHIFT_W'(S_BASE - hi);
    entry_o.ctl.pos     = apos_q + POS_W'(py_q >> DIV15_SH);
  end

endmodule

@@ rtl/pvcur_queue.sv @@
// Short queue between the front end and the back end.
`include "pv_current_from_voltage_unit_defines.svh"
module pvcur_queue import pvcur_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  pvcur_entry_t entry_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output pvcur_entry_t entry_o
);

  pvcur_entry_t      mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `PVCUR_NEVER(a_queue_overflow, push_i && full_o, "push into a full queue")
  `PVCUR_NEVER(a_queue_underflow, pop_i && empty_o, "pop from an empty queue")
  `PVCUR_ASSERT(a_queue_count, push_i && !pop_i |=> count_q == $past(count_q) + QCNT_W'(1), "queue count lost a push")

endmodule

@@ rtl/pvcur_back.sv @@
// Back end: exponential, current code and the two DAC words.
`include "pv_current_from_voltage_unit_defines.svh"
module pvcur_back import pvcur_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  pvcur_entry_t      entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              dac_channel_o,
  output logic [CODE_W-1:0] dac_code_o,
  output logic [SPI_W-1:0]  spi_word_o,
  output logic              last_o
);

  logic adv;

  logic [IDX_W:0]  ka;
  logic [IDX_W:0]  kb;
  logic [ROM_W-1:0] t0;
  logic [ROM_W-1:0] t1;

  logic             s1_valid_q;
  logic [ROM_W-1:0] s1_t0_q;
  logic [ROM_W-1:0] s1_d_q;
  logic [REM_W-1:0] s1_rem_q;
  pvcur_ctl_t       s1_ctl_q;

  logic              s2_valid_q;
  logic [ROM_W-1:0]  s2_t0_q;
  logic [PROD_W-1:0] s2_prod_q;
  pvcur_ctl_t        s2_ctl_q;

  logic             s3_valid_q;
  logic [ROM_W-1:0] s3_m_q;
  pvcur_ctl_t       s3_ctl_q;

  logic                 s4_valid_q;
  logic [NEG_SUM_W-1:0] s4_mhi_q;
  logic [MLO_W-1:0]     s4_mlo_q;
  pvcur_ctl_t           s4_ctl_q;

  logic                 s5_valid_q;
  logic [NEG_SUM_W-1:0] s5_sum_q;
  pvcur_ctl_t           s5_ctl_q;

  logic [NEG_SUM_W-1:0] neg;
  logic [POS_W-1:0]     diff;
  logic [RAW_W-1:0]     raw;
  logic [CODE_W-1:0]    code_d;

  logic              out_valid_q;
  logic              last_q;
  logic [CODE_W-1:0] code_q;

  assign adv   = !out_valid_q || (out_ready_i && last_q);
  assign pop_o = adv && !empty_i;

  assign ka = {1'b0, entry_i.frac[FRAC_W-1 -: IDX_W]};
  assign kb = ka + (IDX_W+1)'(1);
  assign t0 = EXP_ROM[ka];
  assign t1 = EXP_ROM[kb];

  always_comb begin
    neg  = s5_sum_q >> s5_ctl_q.shamt;
    diff = s5_ctl_q.pos - POS_W'(neg);
    raw  = diff[POS_W-1:POS_FRAC];
    if (s5_ctl_q.huge || (neg >= NEG_SUM_W'(s5_ctl_q.pos))) begin
      code_d = '0;
    end else if (raw > RAW_W'(DAC_MAX)) begin
      code_d = DAC_MAX;
    end else begin
      code_d = CODE_W'(raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= pop_o;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      out_valid_q <= s5_valid_q;
      last_q      <= 1'b0;
    end else if (out_ready_i && !last_q) begin
      last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_t0_q   <= t0;
      s1_d_q    <= (t1 > t0) ? (t1 - t0) : '0;
      s1_rem_q  <= entry_i.frac[REM_W-1:0];
      s1_ctl_q  <= entry_i.ctl;

      s2_t0_q   <= s1_t0_q;
      s2_prod_q <= PROD_W'(s1_d_q) * PROD_W'(s1_rem_q);
      s2_ctl_q  <= s1_ctl_q;

      s3_m_q    <= s2_t0_q + ROM_W'(s2_prod_q >> REM_W);
      s3_ctl_q  <= s2_ctl_q;

      s4_mhi_q  <= NEG_SUM_W'(s3_m_q) * EXP_MUL_HI;
      s4_mlo_q  <= MLO_W'({s3_m_q, 1'b0}) * MLO_W'(DIV3_M);
      s4_ctl_q  <= s3_ctl_q;

      s5_sum_q  <= s4_mhi_q + NEG_SUM_W'(s4_mlo_q >> DIV3_SH)
                 + (NEG_SUM_W'(1) << (s4_ctl_q.shamt - SHIFT_W'(1)));
      s5_ctl_q  <= s4_ctl_q;

      code_q    <= code_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign last_o        = last_q;
  assign dac_channel_o = !last_q;
  assign dac_code_o    = last_q ? VLIMIT_CODE : code_q;
  assign spi_word_o    = {dac_channel_o, {(SPI_W-1){1'b0}}} | SPI_CMD | SPI_W'(dac_code_o);

  `PVCUR_ASSERT(a_pair_order, out_valid_o && out_ready_i && !last_o |=> out_valid_o && last_o, "second word of the pair missing")
  `PVCUR_ASSERT(a_stage_hold, s5_valid_q && !adv |=> s5_valid_q, "finished code dropped during a stall")

endmodule

@@ rtl/pv_current_from_voltage_unit.sv @@
// Top level: photovoltaic panel current emulator, ADC sample in, DAC word pair out.
//
// Input channel in_valid_i/in_ready_o carries one ADC load-voltage sample.
// Each sample gives two transfers on out_valid_o/out_ready_i: the current
// reference word on channel 1, then the voltage-limit word on channel 0
// with last_o set. spi_word_o is the ready-made 16-bit DAC command word.
// The config channel cfg_valid_i/cfg_ready_o writes irradiance (index 0)
// or temperature (index 1); cfg_ready_o is always high and writes to other
// indexes are dropped. Write config only while no sample is in flight.
// The first word passes the front stages, the queue and the back-end
// stages; the second word follows in the cycle after the first is taken.
// A front pipeline of two stages feeds a four-entry queue; the back end
// is a six-stage pipeline ending in the output word register. The back
// end moves on to the next sample only once the second word is taken.
// When the receiver stalls, the back end holds, the queue fills and then
// in_ready_o drops. Reset empties all pipelines and the queue and loads
// irradiance 900 and temperature 25.
module pv_current_from_voltage_unit import pvcur_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ADC_BITS-1:0]   adc_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  dac_channel_o,
  output logic [CODE_W-1:0]     dac_code_o,
  output logic [SPI_W-1:0]      spi_word_o,
  output logic                  last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [IRR_W-1:0]  irradiance_q;
  logic [TEMP_W-1:0] temperature_q;

  logic         push;
  logic         full;
  logic         pop;
  logic         empty;
  pvcur_entry_t push_entry;
  pvcur_entry_t head_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irradiance_q  <= IRR_RESET;
      temperature_q <= TEMP_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IRRADIANCE: begin
          irradiance_q <= cfg_data_i[IRR_W-1:0];
        end
        REG_TEMPERATURE: begin
          temperature_q <= cfg_data_i[TEMP_W-1:0];
        end
        default: begin
          irradiance_q <= irradiance_q;
        end
      endcase
    end
  end

  pvcur_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .adc_sample_i  (adc_sample_i),
    .irradiance_i  (irradiance_q),
    .temperature_i (temperature_q),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  pvcur_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (head_entry)
  );

  pvcur_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .dac_channel_o (dac_channel_o),
    .dac_code_o    (dac_code_o),
    .spi_word_o    (spi_word_o),
    .last_o        (last_o)
  );

endmodule
